[rtl/core/ffd_pkg.sv]
// Shared constants and types for the fractional feedback delay.
package ffd_pkg;

  // Default structural sizes.
  localparam int CHANNELS_DEF    = 2;
  localparam int DEPTH_DEF       = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int DELAY_W    = 20;
  localparam int GAIN_W     = 16;
  localparam int BLEN_W     = 13;
  localparam int GAIN_FRAC  = 15;

  localparam logic [DELAY_W-1:0] DELAY_RST = 20'd256;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd0;
  localparam logic [BLEN_W-1:0]  BLEN_RST  = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_BLEN  = 2'd2
  } cfg_reg_t;

  // Result queue depth; also the limit on words in flight.
  localparam int OFIFO_DEPTH = 4;

endpackage

[rtl/core/ffd_ram.sv]
// Generic RAM: one write port, two registered read ports.
module ffd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/core/fractional_feedback_delay.sv]
// Multichannel fractional delay line with feedback and linear interpolation.
// After reset the block sweeps the sample memory to zero, one entry per cycle;
// s_tready stays low until the sweep ends. m_tvalid rises once an accepted word
// has passed stages 1 to 4 and been written into the result queue. Words of
// different channels follow each other every cycle while s_tready is high, but a
// channel can take its next word only once its previous one has reached stage 4,
// because the feedback loop (gain multiply, memory write and read,
// interpolation multiply) passes through four stages. Up to four words may be in
// flight or waiting at the output; the result queue keeps accepting while the
// output side stalls. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module fractional_feedback_delay #(
  parameter int CHANNELS    = ffd_pkg::CHANNELS_DEF,
  parameter int DEPTH       = ffd_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = ffd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ffd_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // Input words.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample_in
  input  logic                                  s_tuser,  // channel
  // Result words.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // sample_out
  output logic                                  m_tuser,  // channel_out
  // Configuration writes.
  input  logic                                  cfg_we,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int TDW   = ((SB + 7) / 8) * 8;
  localparam int TOTAL = CHANNELS * DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int DW    = LW + F;
  localparam int DXW   = (DW > ffd_pkg::DELAY_W) ? DW : ffd_pkg::DELAY_W;
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PB    = ffd_pkg::GAIN_W + SB;
  localparam int OFD   = ffd_pkg::OFIFO_DEPTH;
  localparam int QPW   = $clog2(OFD);
  localparam int QCW   = $clog2(OFD + 1);

  // Configuration registers.
  logic [ffd_pkg::DELAY_W-1:0]       delay_samples;
  logic signed [ffd_pkg::GAIN_W-1:0] feedback_gain;
  logic [ffd_pkg::BLEN_W-1:0]        buffer_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= ffd_pkg::DELAY_RST;
      feedback_gain <= ffd_pkg::GAIN_RST;
      buffer_length <= ffd_pkg::BLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ffd_pkg::REG_DELAY: delay_samples <= cfg_data[ffd_pkg::DELAY_W-1:0];
        ffd_pkg::REG_GAIN:  feedback_gain <= cfg_data[ffd_pkg::GAIN_W-1:0];
        ffd_pkg::REG_BLEN:  buffer_length <= cfg_data[ffd_pkg::BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped length and delay, registered once per cycle from the settings.
  logic [31:0]    blen_ext;
  logic [LW-1:0]  len_c;
  logic [DXW-1:0] dly_ext;
  logic [DXW-1:0] dly_lo;
  logic [DXW-1:0] dly_hi;
  logic [DXW-1:0] dly_c;
  logic [LW-1:0]  len_q;
  logic [DW-1:0]  dly_q;

  always_comb begin
    blen_ext = 32'(buffer_length);
    if (blen_ext < 32'd2) begin
      len_c = LW'(2);
    end else if (blen_ext > 32'(DEPTH)) begin
      len_c = LW'(DEPTH);
    end else begin
      len_c = LW'(blen_ext);
    end
    dly_ext = DXW'(delay_samples);
    dly_lo  = DXW'(1) << F;
    dly_hi  = DXW'({len_c, {F{1'b0}}});
    if (dly_ext < dly_lo) begin
      dly_c = dly_lo;
    end else if (dly_ext > dly_hi) begin
      dly_c = dly_hi;
    end else begin
      dly_c = dly_ext;
    end
  end

  always_ff @(posedge clk) begin
    len_q <= len_c;
    dly_q <= DW'(dly_c);
  end

  // Clearing sweep after reset.
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(TOTAL - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Per-channel state.
  logic signed [SB-1:0] last_out [CHANNELS];
  logic [PW-1:0]        wpos [CHANNELS];

  // Pipeline registers.
  logic                 st1_valid;
  logic [CIW-1:0]       st1_ch;
  logic                 st1_chf;
  logic signed [SB-1:0] st1_x;

  logic                 st2_valid;
  logic [CIW-1:0]       st2_ch;
  logic                 st2_chf;
  logic signed [SB-1:0] st2_x;
  logic signed [PB-1:0] st2_fbp;
  logic [PW-1:0]        st2_wp;
  logic [PW-1:0]        st2_wpn;
  logic signed [DW:0]   st2_diff;
  logic [AW-1:0]        st2_base;

  logic                 st3_valid;
  logic [CIW-1:0]       st3_ch;
  logic                 st3_chf;
  logic signed [SB-1:0] st3_w;
  logic [F-1:0]         st3_frac;
  logic                 st3_fwd0;
  logic                 st3_fwd1;

  logic                     st4_valid;
  logic [CIW-1:0]           st4_ch;
  logic                     st4_chf;
  logic signed [SB-1:0]     st4_y0;
  logic signed [SB+F+1:0]   st4_prod;

  // Input acceptance. A channel waits while its previous word is still
  // ahead of the last stage, since that word produces the feedback value.
  logic [CIW-1:0] in_ch;
  logic           hazard;
  logic [QCW-1:0] occ;
  logic           in_acc;

  always_comb begin
    in_ch  = (CHANNELS == 1) ? '0 : CIW'(s_tuser);
    hazard = (st1_valid && st1_ch == in_ch) ||
             (st2_valid && st2_ch == in_ch) ||
             (st3_valid && st3_ch == in_ch);
  end

  assign s_tready = !clr_busy && !cfg_we && !hazard && (occ < QCW'(OFD));
  assign in_acc   = s_tvalid && s_tready;

  // Stage 1: feedback product and next positions.
  logic signed [SB-1:0] lo1;
  logic [PW-1:0]        wp1;
  logic [LW-1:0]        wpn_inc;
  logic [PW-1:0]        wpn1;
  logic signed [DW:0]   diff1;

  always_comb begin
    lo1     = last_out[st1_ch];
    wp1     = wpos[st1_ch];
    wpn_inc = LW'(wp1) + LW'(1);
    wpn1    = (wpn_inc >= len_q) ? '0 : wpn_inc[PW-1:0];
    diff1   = $signed({1'b0, DW'({wpn1, {F{1'b0}}})}) - $signed({1'b0, dly_q});
  end

  // Stage 2: saturated write value, memory write and both tap reads.
  logic signed [PB:0]   rnd2;
  logic signed [PB:0]   fbs2;
  logic signed [PB:0]   wsum2;
  logic signed [SB-1:0] w2;
  logic [LW:0]          hi2;
  logic [LW:0]          hi_wrap2;
  logic [PW-1:0]        x0_2;
  logic [LW-1:0]        x0p1_2;
  logic [PW-1:0]        x1_2;

  always_comb begin
    rnd2  = {st2_fbp[PB-1], st2_fbp} + (PB+1)'(1 << (ffd_pkg::GAIN_FRAC - 1));
    fbs2  = rnd2 >>> ffd_pkg::GAIN_FRAC;
    wsum2 = fbs2 + {{(PB+1-SB){st2_x[SB-1]}}, st2_x};
    if ((&wsum2[PB:SB-1]) || !(|wsum2[PB:SB-1])) begin
      w2 = wsum2[SB-1:0];
    end else if (wsum2[PB]) begin
      w2 = {1'b1, {(SB-1){1'b0}}};
    end else begin
      w2 = {1'b0, {(SB-1){1'b1}}};
    end
    // Whole-sample part of the read position, wrapped once at the length.
    hi2      = st2_diff[DW:F];
    hi_wrap2 = hi2 + {1'b0, len_q};
    x0_2     = hi2[LW] ? hi_wrap2[PW-1:0] : hi2[PW-1:0];
    x0p1_2   = LW'(x0_2) + LW'(1);
    x1_2     = (x0p1_2 >= len_q) ? '0 : x0p1_2[PW-1:0];
  end

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SB-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr0;
  logic [AW-1:0] ram_raddr1;
  logic [SB-1:0] ram_rdata0;
  logic [SB-1:0] ram_rdata1;

  assign ram_we     = clr_busy || st2_valid;
  assign ram_waddr  = clr_busy ? clr_addr : st2_base + AW'(st2_wp);
  assign ram_wdata  = clr_busy ? '0 : w2;
  assign ram_raddr0 = st2_base + AW'(x0_2);
  assign ram_raddr1 = st2_base + AW'(x1_2);

  ffd_ram #(
    .WIDTH (SB),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  // Stage 3: taps, forwarding the value written alongside the tap reads.
  logic signed [SB-1:0] y0_3;
  logic signed [SB-1:0] y1_3;
  logic signed [SB:0]   dy3;

  always_comb begin
    y0_3 = st3_fwd0 ? st3_w : ram_rdata0;
    y1_3 = st3_fwd1 ? st3_w : ram_rdata1;
    dy3  = {y1_3[SB-1], y1_3} - {y0_3[SB-1], y0_3};
  end

  // Stage 4: floor of the interpolated value; it lies between the taps.
  logic signed [SB+F+1:0] acc4;
  logic signed [SB-1:0]   y4;

  always_comb begin
    acc4 = {{2{st4_y0[SB-1]}}, st4_y0, {F{1'b0}}} + st4_prod;
    y4   = acc4[SB+F-1:F];
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
    end else begin
      st1_valid <= in_acc;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
      st4_valid <= st3_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    st1_ch  <= in_ch;
    st1_chf <= s_tuser;
    st1_x   <= s_tdata[SB-1:0];

    st2_ch   <= st1_ch;
    st2_chf  <= st1_chf;
    st2_x    <= st1_x;
    st2_fbp  <= feedback_gain * lo1;
    st2_wp   <= wp1;
    st2_wpn  <= wpn1;
    st2_diff <= diff1;
    st2_base <= AW'(32'(st1_ch) * DEPTH);

    st3_ch   <= st2_ch;
    st3_chf  <= st2_chf;
    st3_w    <= w2;
    st3_frac <= st2_diff[F-1:0];
    st3_fwd0 <= (x0_2 == st2_wp);
    st3_fwd1 <= (x1_2 == st2_wp);

    st4_ch   <= st3_ch;
    st4_chf  <= st3_chf;
    st4_y0   <= y0_3;
    st4_prod <= dy3 * $signed({1'b0, st3_frac});
  end

  // Per-channel state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_out[i] <= '0;
        wpos[i]     <= '0;
      end
    end else begin
      if (st2_valid) begin
        wpos[st2_ch] <= st2_wpn;
      end
      if (st4_valid) begin
        last_out[st4_ch] <= y4;
      end
    end
  end

  // Result queue.
  logic [SB-1:0]  q_y [OFD];
  logic           q_c [OFD];
  logic [QPW-1:0] q_wr;
  logic [QPW-1:0] q_rd;
  logic [QCW-1:0] q_cnt;
  logic           q_pop;

  assign m_tvalid = (q_cnt != '0);
  assign q_pop    = m_tvalid && m_tready;
  assign m_tdata  = TDW'(q_y[q_rd]);
  assign m_tuser  = q_c[q_rd];

  always_ff @(posedge clk) begin
    if (st4_valid) begin
      q_y[q_wr] <= y4;
      q_c[q_wr] <= st4_chf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
      occ   <= '0;
    end else begin
      if (st4_valid) begin
        q_wr <= q_wr + QPW'(1);
      end
      if (q_pop) begin
        q_rd <= q_rd + QPW'(1);
      end
      q_cnt <= q_cnt + QCW'(st4_valid) - QCW'(q_pop);
      occ   <= occ + QCW'(in_acc) - QCW'(q_pop);
    end
  end

endmodule

[rtl/core/ffd_checker.sv]
// Port-level checks for the fractional feedback delay, bound to the top level.
module ffd_checker #(
  parameter int SAMPLE_BITS = ffd_pkg::SAMPLE_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
  input logic                                m_tuser
);

  localparam int OFD = ffd_pkg::OFIFO_DEPTH;
  localparam int PCW = $clog2(OFD + 2);

  // Words accepted but not yet delivered.
  logic [PCW-1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + PCW'(s_tvalid && s_tready) - PCW'(m_tvalid && m_tready);
    end
  end

  // The memory sweep holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted right after reset");

  a_no_output_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_no_invented_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != '0)
    else $error("result word without a pending input word");

  a_in_flight_limit: assert property (@(posedge clk) disable iff (rst)
    pend <= PCW'(OFD))
    else $error("more words in flight than the result queue holds");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

endmodule

bind fractional_feedback_delay ffd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ffd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[dv/fractional_feedback_delay_tb.sv]
// Self-checking testbench for the fractional feedback delay: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module fractional_feedback_delay_tb;
  import ffd_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int DATA_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int TAP_DEPTH = DEPTH_DEF;
  localparam int NUM_CH = CHANNELS_DEF;
  localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 222;

  typedef struct packed {
    logic                channel;
    logic [SAMPLE_W-1:0] sample;
  } tap_word_t;

  // Keeps its own copy of the delay store and registers and queues the word
  // that each accepted input must produce.
  class delay_scoreboard;
    logic signed [SAMPLE_W-1:0] tap_mem [NUM_CH][TAP_DEPTH];
    logic [11:0]                wr_pos [NUM_CH];
    logic signed [SAMPLE_W-1:0] prev_out [NUM_CH];
    logic [DELAY_W-1:0]         delay_q8;
    logic signed [GAIN_W-1:0]   fb_gain;
    logic [BLEN_W-1:0]          buf_len;
    tap_word_t                  expected_taps[$];
    int                         failures;

    function new();
      foreach (tap_mem[c, i]) tap_mem[c][i] = '0;
      foreach (wr_pos[c]) begin
        wr_pos[c] = '0;
        prev_out[c] = '0;
      end
      delay_q8 = DELAY_RST;
      fb_gain = GAIN_RST;
      buf_len = BLEN_RST;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY: delay_q8 = data[DELAY_W-1:0];
        REG_GAIN: fb_gain = data[GAIN_W-1:0];
        REG_BLEN: buf_len = data[BLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function tap_word_t predict_delayed_sample(logic ch, logic signed [SAMPLE_W-1:0] x);
      longint len, fb, w, d, dmax, rp, frac, y0, y1, y, pos, x0, x1;
      int c;
      tap_word_t res;
      c = int'(ch) % NUM_CH;
      len = longint'(buf_len);
      if (len < 2) len = 2;
      if (len > TAP_DEPTH) len = TAP_DEPTH;

      // Feedback is rounded half up to the sample grid, then the sum saturates.
      fb = (longint'(fb_gain) * longint'(prev_out[c]) + 64'sd16384) >>> GAIN_FRAC;
      w = longint'(x) + fb;
      if (w > SMP_MAX) w = SMP_MAX;
      if (w < SMP_MIN) w = SMP_MIN;

      // A position left over from a longer length still takes the write.
      pos = longint'(wr_pos[c]);
      tap_mem[c][pos] = w[SAMPLE_W-1:0];
      pos = pos + 1;
      if (pos >= len) pos = 0;
      wr_pos[c] = pos[11:0];

      d = longint'(delay_q8);
      dmax = len <<< FRAC_BITS_DEF;
      if (d < (64'sd1 <<< FRAC_BITS_DEF)) d = 64'sd1 <<< FRAC_BITS_DEF;
      if (d > dmax) d = dmax;
      rp = (pos <<< FRAC_BITS_DEF) - d;
      if (rp < 0) rp = rp + dmax;
      x0 = (rp >>> FRAC_BITS_DEF) % len;
      x1 = x0 + 1;
      if (x1 >= len) x1 = 0;
      frac = rp & ((64'sd1 <<< FRAC_BITS_DEF) - 1);

      y0 = longint'(tap_mem[c][x0]);
      y1 = longint'(tap_mem[c][x1]);
      y = (y0 * (64'sd1 <<< FRAC_BITS_DEF) + (y1 - y0) * frac) >>> FRAC_BITS_DEF;
      prev_out[c] = y[SAMPLE_W-1:0];
      res.channel = ch;
      res.sample = y[SAMPLE_W-1:0];
      return res;
    endfunction

    function void note_input(logic ch, logic [SAMPLE_W-1:0] x);
      expected_taps.push_back(predict_delayed_sample(ch, x));
    endfunction

    function void check_output(logic ch, logic [SAMPLE_W-1:0] y);
      tap_word_t exp_word;
      if (expected_taps.size() == 0) begin
        $error("unexpected result word: channel_out %0d, sample_out %0d", ch, $signed(y));
        failures++;
        return;
      end
      exp_word = expected_taps.pop_front();
      if (ch !== exp_word.channel) begin
        $error("channel_out mismatch: expected %0d, got %0d", exp_word.channel, ch);
        failures++;
      end
      if (y !== exp_word.sample) begin
        $error("sample_out mismatch: expected %0d, got %0d",
               $signed(exp_word.sample), $signed(y));
        failures++;
      end
    endfunction

    function int pending();
      return expected_taps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;  // sample_in
  logic s_tuser = 1'b0;             // channel
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;       // sample_out
  logic m_tuser;                    // channel_out
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  delay_scoreboard sb = new();
  int src_idle_pct = 30;
  int sink_idle_pct = 49;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;

  fractional_feedback_delay u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[SAMPLE_W-1:0]);
      if (m_tvalid && m_tready) sb.check_output(m_tuser, m_tdata[SAMPLE_W-1:0]);
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_word(input logic ch, input logic [SAMPLE_W-1:0] smp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ch;
    s_tdata <= DATA_W'(smp);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers change only once every word in flight has come out.
  task automatic set_config(input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] gain,
                            input logic [BLEN_W-1:0] blen);
    stop_sending();
    wait_drain();
    write_reg(REG_DELAY, CFG_DATA_W'(dly));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_BLEN, CFG_DATA_W'(blen));
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SAMPLE_W'(SMP_MAX);
      1: return SAMPLE_W'(SMP_MIN);
      2: return SAMPLE_W'($urandom_range(1023)) - SAMPLE_W'(512);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] gain,
                           input logic [BLEN_W-1:0] blen, input bit pressure);
    set_config(dly, gain, blen);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      // The output stalls for a long stretch while words keep coming, so the
      // result queue fills and the input side backs up.
      if (pressure && i == ITEMS_PER_PHASE / 3) hold_request = 300;
      if (pressure && i == (2 * ITEMS_PER_PHASE) / 3) begin
        stop_sending();
        wait_drain();
      end
      send_word(1'($urandom_range(1)), rand_sample());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers: one-sample delay, no feedback, full length.
    send_word(1'b0, SAMPLE_W'(SMP_MAX));
    send_word(1'b1, SAMPLE_W'(SMP_MIN));
    send_word(1'b0, '0);
    send_word(1'b1, '1);
    send_word(1'b0, SAMPLE_W'(1));
    send_word(1'b1, SAMPLE_W'(SMP_MAX));

    // Length shrinks to the current write position, so the position is out of range;
    // full positive gain drives the stored sums into saturation.
    set_config(20'd384, 16'h7FFF, 13'd3);
    repeat (3) send_word(1'b0, SAMPLE_W'(SMP_MAX));
    repeat (3) send_word(1'b1, SAMPLE_W'(SMP_MIN));

    // Most negative gain flips the sign of extreme outputs.
    set_config(20'd640, 16'h8000, 13'd3);
    send_word(1'b0, SAMPLE_W'(SMP_MIN));
    send_word(1'b1, SAMPLE_W'(SMP_MAX));
    send_word(1'b0, SAMPLE_W'(SMP_MAX));
    send_word(1'b1, SAMPLE_W'(SMP_MIN));

    // Length below two with a delay under one sample.
    set_config(20'd0, 16'h4000, 13'd1);
    send_word(1'b0, SAMPLE_W'(12345));
    send_word(1'b1, SAMPLE_W'(-12345));

    // Length past the store size with the largest delay word.
    set_config(20'hFFFFF, 16'hFFFF, 13'h1FFF);
    send_word(1'b0, SAMPLE_W'(SMP_MAX));
    send_word(1'b1, SAMPLE_W'(SMP_MIN));

    // A write to an index past the register list changes nothing.
    stop_sending();
    wait_drain();
    write_reg(REG_UNUSED, 20'hABCDE);
    send_word(1'b0, SAMPLE_W'(777));
    send_word(1'b1, SAMPLE_W'(-777));

    run_phase(20'd896, 16'h4000, 13'd64, 1'b0);
    run_phase(20'd0, 16'h8000, 13'd2, 1'b1);
    run_phase(20'd1047552, 16'h7FFF, 13'd37, 1'b0);

    src_idle_pct = 49;
    sink_idle_pct = 30;
    run_phase(20'd2637, 16'hC000, 13'd4096, 1'b0);
    run_phase(20'hFFFFF, 16'h0000, 13'h1FFF, 1'b1);
    run_phase(20'd512, 16'hFFFF, 13'd0, 1'b0);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_phase(DELAY_W'($urandom_range(40 * 256)), GAIN_W'($urandom),
              BLEN_W'($urandom_range(2, 64)), 1'b1);
    run_phase(DELAY_W'($urandom_range(300 * 256)), GAIN_W'($urandom),
              BLEN_W'($urandom_range(2, 300)), 1'b0);

    stop_sending();
    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
